// File: hw/rtl/otq_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the ordered timer queue.
// No dependencies; every other file of the block imports this package.
package otq_pkg;

    localparam int SLOTS    = 16;
    localparam int MAX_FIRE = 16;
    localparam int TIME_W   = 48;
    localparam int NUM_W    = 32;
    localparam int IDX_W    = $clog2(MAX_FIRE);
    localparam int CNT_W    = $clog2(MAX_FIRE + 1);

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_CANCEL = 2'd1,
        OP_EXPIRE = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_APPENDED  = 3'd0,
        ST_FULL      = 3'd1,
        ST_CANCELLED = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_EXPIRED   = 3'd4,
        ST_NONE      = 3'd5
    } status_t;

    typedef struct packed {
        logic              valid;
        logic [TIME_W-1:0] deadline;
        logic [TIME_W-1:0] interval;
        logic [NUM_W-1:0]  number;
    } otq_entry_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t        cmd;
        otq_entry_t       new_entry;
        logic [NUM_W-1:0] cancel_id;
        logic             found_in;
    } otq_cell_ctl_t;

endpackage

// File: hw/rtl/ordered_timer_queue.sv
`timescale 1ns / 1ps
// Ordered timer queue: a sorted chain of timer cells with a small controller.
// Depends on otq_pkg and otq_cell.
//
// Usage:
//   The s_ channel takes one command word (append, cancel or expire); the
//   m_ channel returns result words, m_last marking the final word of a
//   command. Every word carries the earliest armed deadline after the command.
//   Timers sit in a chain of SLOTS cells kept sorted by deadline, then by
//   creation number; cell 0 always holds the earliest timer.
// Command flow:
//   Append and cancel act on the chain in the accept cycle; their one result
//   word is registered from S_RESP once the result register is free. An
//   expire that fires N timers (N at most MAX_FIRE) pops one timer per cycle
//   from cell 0, re-arms each fired periodic timer with an add, then a sorted
//   insert, then emits N words, one per cycle while the receiver takes them.
//   An expire with nothing due gives one none-expired word.
// Reset: all cells go empty and the creation number returns to zero.
// Stall: the result register holds its word while m_ready is low; the queue
//   accepts a new command word once its previous command is fully emitted
//   into the result register, even while that word still waits.
module ordered_timer_queue
    import otq_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_operation,
    input  logic [TIME_W-1:0] s_deadline,
    input  logic [TIME_W-1:0] s_repeat_interval,
    input  logic [NUM_W-1:0]  s_cancel_id,
    input  logic [TIME_W-1:0] s_current_time,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [2:0]        m_status,
    output logic [NUM_W-1:0]  m_timer_number,
    output logic [TIME_W-1:0] m_fired_deadline,
    output logic              m_new_earliest,
    output logic              m_next_valid,
    output logic [TIME_W-1:0] m_next_deadline,
    output logic              m_last
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP,
        S_CALC,
        S_INS,
        S_RESP
    } state_t;

    state_t            state_reg, state_next;
    logic [NUM_W-1:0]  next_number_reg, next_number_next;
    logic [TIME_W-1:0] now_reg, now_next;
    status_t           res_status_reg, res_status_next;
    logic [NUM_W-1:0]  res_number_reg, res_number_next;
    logic              res_ec_reg, res_ec_next;
    logic [CNT_W-1:0]  fire_cnt_reg, fire_cnt_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    otq_entry_t        rearm_reg, rearm_next;

    logic              m_valid_reg, m_valid_next;
    logic [2:0]        m_status_reg, m_status_next;
    logic [NUM_W-1:0]  m_number_reg, m_number_next;
    logic [TIME_W-1:0] m_fired_reg, m_fired_next;
    logic              m_ec_reg, m_ec_next;
    logic              m_nvalid_reg, m_nvalid_next;
    logic [TIME_W-1:0] m_ndl_reg, m_ndl_next;
    logic              m_last_reg, m_last_next;

    otq_entry_t        fire_buf_reg [MAX_FIRE];
    logic              buf_we;
    otq_entry_t        buf_rd;

    otq_cell_ctl_t     ctl;
    otq_entry_t        cell_q [SLOTS];
    logic              cell_stay [SLOTS];
    logic              cell_found [SLOTS];
    otq_entry_t        head;
    logic              full;
    logic              accept;
    logic              out_free;
    logic              last_idx;
    logic [TIME_W:0]   rearm_sum;

    // chain of cells: insert shifts right, remove shifts left
    for (genvar i = 0; i < SLOTS; i++) begin : g_cell
        otq_entry_t left_e;
        otq_entry_t right_e;
        logic       left_s;
        logic       fin;
        if (i == 0) begin : g_first
            assign left_e = '0;
            assign left_s = 1'b1;
            assign fin    = ctl.found_in;
        end else begin : g_mid
            assign left_e = cell_q[i-1];
            assign left_s = cell_stay[i-1];
            assign fin    = cell_found[i-1];
        end
        if (i == SLOTS - 1) begin : g_last
            assign right_e = '0;
        end else begin : g_inner
            assign right_e = cell_q[i+1];
        end
        otq_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctl         (ctl),
            .left_entry  (left_e),
            .left_stay   (left_s),
            .right_entry (right_e),
            .found_in    (fin),
            .entry       (cell_q[i]),
            .stay        (cell_stay[i]),
            .found_out   (cell_found[i])
        );
    end

    assign head     = cell_q[0];
    assign full     = cell_q[SLOTS-1].valid;
    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign buf_rd   = fire_buf_reg[idx_reg];
    assign last_idx = (CNT_W'(idx_reg) == (fire_cnt_reg - CNT_W'(1)));
    assign rearm_sum = {1'b0, now_reg} + {1'b0, buf_rd.interval};

    always_comb begin
        state_next       = state_reg;
        next_number_next = next_number_reg;
        now_next         = now_reg;
        res_status_next  = res_status_reg;
        res_number_next  = res_number_reg;
        res_ec_next      = res_ec_reg;
        fire_cnt_next    = fire_cnt_reg;
        idx_next         = idx_reg;
        rearm_next       = rearm_reg;
        buf_we           = 1'b0;
        ctl              = '{cmd: CELL_HOLD, new_entry: '0,
                             cancel_id: s_cancel_id, found_in: 1'b0};

        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_number_next = m_number_reg;
        m_fired_next  = m_fired_reg;
        m_ec_next     = m_ec_reg;
        m_nvalid_next = m_nvalid_reg;
        m_ndl_next    = m_ndl_reg;
        m_last_next   = m_last_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    unique case (s_operation)
                        OP_APPEND: begin
                            state_next = S_RESP;
                            if (full) begin
                                res_status_next = ST_FULL;
                                res_number_next = '0;
                                res_ec_next     = 1'b0;
                            end else begin
                                ctl.cmd       = CELL_INSERT;
                                ctl.new_entry = '{valid: 1'b1, deadline: s_deadline,
                                                  interval: s_repeat_interval,
                                                  number: next_number_reg};
                                res_status_next  = ST_APPENDED;
                                res_number_next  = next_number_reg;
                                res_ec_next      = !head.valid || (s_deadline < head.deadline);
                                next_number_next = next_number_reg + NUM_W'(1);
                            end
                        end
                        OP_CANCEL: begin
                            ctl.cmd         = CELL_REMOVE;
                            state_next      = S_RESP;
                            res_status_next = cell_found[SLOTS-1] ? ST_CANCELLED
                                                                  : ST_NOT_FOUND;
                            res_number_next = s_cancel_id;
                            res_ec_next     = 1'b0;
                        end
                        OP_EXPIRE: begin
                            now_next      = s_current_time;
                            fire_cnt_next = '0;
                            state_next    = S_POP;
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_POP: begin
                // pop the head while it is due
                if (head.valid && (head.deadline <= now_reg) &&
                    (fire_cnt_reg < CNT_W'(MAX_FIRE))) begin
                    ctl.cmd       = CELL_REMOVE;
                    ctl.found_in  = 1'b1;
                    buf_we        = 1'b1;
                    fire_cnt_next = fire_cnt_reg + CNT_W'(1);
                end else begin
                    idx_next = '0;
                    if (fire_cnt_reg == '0) begin
                        res_status_next = ST_NONE;
                        res_number_next = '0;
                        res_ec_next     = 1'b0;
                        state_next      = S_RESP;
                    end else begin
                        res_status_next = ST_EXPIRED;
                        state_next      = S_CALC;
                    end
                end
            end
            S_CALC: begin
                // saturate the re-armed deadline at the top of the time range
                rearm_next.valid    = 1'b1;
                rearm_next.deadline = rearm_sum[TIME_W] ? '1 : rearm_sum[TIME_W-1:0];
                rearm_next.interval = buf_rd.interval;
                rearm_next.number   = buf_rd.number;
                state_next          = S_INS;
            end
            S_INS: begin
                if (rearm_reg.interval != '0) begin
                    ctl.cmd       = CELL_INSERT;
                    ctl.new_entry = rearm_reg;
                end
                if (last_idx) begin
                    idx_next   = '0;
                    state_next = S_RESP;
                end else begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = S_CALC;
                end
            end
            S_RESP: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_nvalid_next = head.valid;
                    m_ndl_next    = head.valid ? head.deadline : '0;
                    m_status_next = res_status_reg;
                    if (res_status_reg == ST_EXPIRED) begin
                        m_number_next = buf_rd.number;
                        m_fired_next  = buf_rd.deadline;
                        m_ec_next     = 1'b0;
                        m_last_next   = last_idx;
                        if (last_idx) begin
                            state_next = S_IDLE;
                        end else begin
                            idx_next = idx_reg + IDX_W'(1);
                        end
                    end else begin
                        m_number_next = res_number_reg;
                        m_fired_next  = '0;
                        m_ec_next     = res_ec_reg;
                        m_last_next   = 1'b1;
                        state_next    = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            next_number_reg <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            next_number_reg <= next_number_next;
            m_valid_reg     <= m_valid_next;
        end
        now_reg        <= now_next;
        res_status_reg <= res_status_next;
        res_number_reg <= res_number_next;
        res_ec_reg     <= res_ec_next;
        fire_cnt_reg   <= fire_cnt_next;
        idx_reg        <= idx_next;
        rearm_reg      <= rearm_next;
        m_status_reg   <= m_status_next;
        m_number_reg   <= m_number_next;
        m_fired_reg    <= m_fired_next;
        m_ec_reg       <= m_ec_next;
        m_nvalid_reg   <= m_nvalid_next;
        m_ndl_reg      <= m_ndl_next;
        m_last_reg     <= m_last_next;
    end

    // hold fired timers for re-arm and result emission
    always_ff @(posedge aclk) begin
        if (buf_we) begin
            fire_buf_reg[fire_cnt_reg[IDX_W-1:0]] <= head;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_timer_number   = m_number_reg;
    assign m_fired_deadline = m_fired_reg;
    assign m_new_earliest   = m_ec_reg;
    assign m_next_valid     = m_nvalid_reg;
    assign m_next_deadline  = m_ndl_reg;
    assign m_last           = m_last_reg;

endmodule

// File: hw/rtl/otq_cell.sv
`timescale 1ns / 1ps
// One cell of the sorted timer chain: holds one entry, shifts with neighbors.
// Depends on otq_pkg.
module otq_cell
    import otq_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  otq_cell_ctl_t ctl,
    input  otq_entry_t    left_entry,
    input  logic          left_stay,
    input  otq_entry_t    right_entry,
    input  logic          found_in,
    output otq_entry_t    entry,
    output logic          stay,
    output logic          found_out
);

    logic              valid_reg;
    logic [TIME_W-1:0] deadline_reg;
    logic [TIME_W-1:0] interval_reg;
    logic [NUM_W-1:0]  number_reg;
    otq_entry_t        entry_next;
    logic              new_first;

    assign entry = '{valid: valid_reg, deadline: deadline_reg,
                     interval: interval_reg, number: number_reg};

    // new entry goes ahead of this one
    assign new_first = (ctl.new_entry.deadline < deadline_reg) ||
                       ((ctl.new_entry.deadline == deadline_reg) &&
                        (ctl.new_entry.number < number_reg));
    assign stay      = valid_reg && !new_first;
    assign found_out = found_in || (valid_reg && (number_reg == ctl.cancel_id));

    always_comb begin
        entry_next = entry;
        case (ctl.cmd)
            CELL_INSERT: begin
                if (!stay) begin
                    entry_next = left_stay ? ctl.new_entry : left_entry;
                end
            end
            CELL_REMOVE: begin
                if (found_out) begin
                    entry_next = right_entry;
                end
            end
            default: entry_next = entry;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= entry_next.valid;
        end
        deadline_reg <= entry_next.deadline;
        interval_reg <= entry_next.interval;
        number_reg   <= entry_next.number;
    end

endmodule

// File: hw/rtl/otq_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the ordered timer queue, bound to the top level.
// Depends on otq_pkg.
module otq_checker
    import otq_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input logic [2:0]        m_status,
    input logic [NUM_W-1:0]  m_timer_number,
    input logic              m_next_valid,
    input logic [TIME_W-1:0] m_next_deadline,
    input logic              m_new_earliest,
    input logic              m_last
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_timer_number))
        else $error("result word changed while stalled");

    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != ST_EXPIRED) |-> m_last)
        else $error("single-word result without last");

    a_next: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_next_valid |-> (m_next_deadline == '0))
        else $error("next deadline set with no armed timer");

    a_ec: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_new_earliest |-> m_status == ST_APPENDED && m_next_valid)
        else $error("earliest change outside a successful append");

endmodule

bind ordered_timer_queue otq_checker u_otq_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_status        (m_status),
    .m_timer_number  (m_timer_number),
    .m_next_valid    (m_next_valid),
    .m_next_deadline (m_next_deadline),
    .m_new_earliest  (m_new_earliest),
    .m_last          (m_last)
);

// File: tb/tb_ordered_timer_queue.sv
`timescale 1ns / 1ps
// Testbench of the ordered timer queue: directed table, then random commands.
// Depends on otq_pkg and the ordered_timer_queue RTL; predicts every result word.
module tb_ordered_timer_queue
    import otq_pkg::*;
();

    localparam int  N_RANDOM  = 300;
    localparam longint CYCLE_LIMIT = 400000;
    localparam logic [TIME_W-1:0] TMAX = {TIME_W{1'b1}};

    // one result word as the queue should emit it
    typedef struct {
        logic [2:0]        status;
        logic [NUM_W-1:0]  number;
        logic [TIME_W-1:0] fired;
        logic              earliest;
        logic              nvalid;
        logic [TIME_W-1:0] ndeadline;
        logic              last;
    } result_word_t;

    // one row of the directed table; chk_status < 0 means predictor only
    typedef struct {
        op_t               op;
        logic [TIME_W-1:0] deadline;
        logic [TIME_W-1:0] interval;
        logic [NUM_W-1:0]  cancel_id;
        logic [TIME_W-1:0] now;
        int                chk_status;
    } command_row_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [1:0]        s_operation = '0;
    logic [TIME_W-1:0] s_deadline = '0;
    logic [TIME_W-1:0] s_repeat_interval = '0;
    logic [NUM_W-1:0]  s_cancel_id = '0;
    logic [TIME_W-1:0] s_current_time = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [2:0]        m_status;
    logic [NUM_W-1:0]  m_timer_number;
    logic [TIME_W-1:0] m_fired_deadline;
    logic              m_new_earliest;
    logic              m_next_valid;
    logic [TIME_W-1:0] m_next_deadline;
    logic              m_last;

    always #1 aclk = ~aclk;

    ordered_timer_queue i_dut (.*);

    // shadow of the timer table
    logic              tmr_valid [SLOTS];
    logic [TIME_W-1:0] tmr_deadline [SLOTS];
    logic [TIME_W-1:0] tmr_interval [SLOTS];
    logic [NUM_W-1:0]  tmr_number [SLOTS];
    logic [NUM_W-1:0]  number_next;

    result_word_t pending_words[$];
    int   errors = 0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   pinned_status[$];   // typed-in status per directed word, -1 = none
    longint cycles = 0;

    function automatic bit sorts_first(int a, int b);
        if (tmr_deadline[a] != tmr_deadline[b]) return tmr_deadline[a] < tmr_deadline[b];
        return tmr_number[a] < tmr_number[b];
    endfunction

    function automatic int earliest_slot();
        int best;
        best = -1;
        for (int i = 0; i < SLOTS; i++)
            if (tmr_valid[i] && (best < 0 || sorts_first(i, best))) best = i;
        return best;
    endfunction

    // apply one command to the shadow table and queue its result words
    task automatic predict_queue(input op_t op, input logic [TIME_W-1:0] dl,
                                 input logic [TIME_W-1:0] iv, input logic [NUM_W-1:0] cid,
                                 input logic [TIME_W-1:0] now, input int pin);
        result_word_t w, burst[$];
        int free_idx, head, hit;
        int fired_idx[$];
        logic [TIME_W:0] sum;
        w = '{default: '0};
        case (op)
            OP_APPEND: begin
                free_idx = -1;
                head = earliest_slot();
                for (int i = SLOTS - 1; i >= 0; i--) if (!tmr_valid[i]) free_idx = i;
                w.last = 1'b1;
                if (free_idx < 0) begin
                    w.status = ST_FULL;
                end else begin
                    w.status = ST_APPENDED;
                    w.number = number_next;
                    w.earliest = (head < 0) || (dl < tmr_deadline[head]);
                    tmr_valid[free_idx] = 1'b1;
                    tmr_deadline[free_idx] = dl;
                    tmr_interval[free_idx] = iv;
                    tmr_number[free_idx] = number_next;
                    number_next++;
                end
                burst = {burst, w};
            end
            OP_CANCEL: begin
                hit = -1;
                for (int i = 0; i < SLOTS; i++)
                    if (tmr_valid[i] && tmr_number[i] == cid && (hit < 0 || sorts_first(i, hit)))
                        hit = i;
                if (hit >= 0) tmr_valid[hit] = 1'b0;
                w.status = (hit >= 0) ? ST_CANCELLED : ST_NOT_FOUND;
                w.number = cid;
                w.last = 1'b1;
                burst = {burst, w};
            end
            OP_EXPIRE: begin
                for (int k = 0; k < MAX_FIRE; k++) begin
                    head = earliest_slot();
                    if (head < 0 || tmr_deadline[head] > now) break;
                    tmr_valid[head] = 1'b0;
                    fired_idx = {fired_idx, head};
                    w = '{default: '0};
                    w.status = ST_EXPIRED;
                    w.number = tmr_number[head];
                    w.fired = tmr_deadline[head];
                    burst = {burst, w};
                end
                // re-arm periodic timers after the whole burst
                foreach (fired_idx[k]) begin
                    if (tmr_interval[fired_idx[k]] != 0) begin
                        sum = now + tmr_interval[fired_idx[k]];
                        tmr_deadline[fired_idx[k]] = sum[TIME_W] ? TMAX : sum[TIME_W-1:0];
                        tmr_valid[fired_idx[k]] = 1'b1;
                    end
                end
                if (burst.size() == 0) begin
                    w = '{default: '0};
                    w.status = ST_NONE;
                    burst = {burst, w};
                end
                burst[burst.size() - 1].last = 1'b1;
            end
            default: ;  // unused code: no state change, no words
        endcase
        head = earliest_slot();
        foreach (burst[k]) begin
            burst[k].nvalid = (head >= 0);
            burst[k].ndeadline = (head >= 0) ? tmr_deadline[head] : '0;
            pending_words = {pending_words, burst[k]};
            pinned_status = {pinned_status, pin};
        end
    endtask

    // drive one command word and hold it until accepted
    task automatic send_command(input logic [1:0] op, input logic [TIME_W-1:0] dl,
                                input logic [TIME_W-1:0] iv, input logic [NUM_W-1:0] cid,
                                input logic [TIME_W-1:0] now, input int pin);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_operation <= op;
        s_deadline <= dl;
        s_repeat_interval <= iv;
        s_cancel_id <= cid;
        s_current_time <= now;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        // the accept edge: predict from the shadow table now
        predict_queue(op_t'(op), dl, iv, cid, now, pin);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    // receiver: random stalls, compare each word to the oldest prediction
    always @(posedge aclk) begin
        result_word_t e;
        int pin;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_words.size() == 0) begin
                    $error("result word with nothing expected, status %0d", m_status);
                    errors++;
                end else begin
                    e = pending_words.pop_front();
                    pin = pinned_status.pop_front();
                    if (pin >= 0 && m_status !== 3'(pin)) begin
                        $error("status (table): expected %0d got %0d", pin, m_status);
                        errors++;
                    end
                    if (m_status !== e.status) begin
                        $error("status: expected %0d got %0d", e.status, m_status); errors++;
                    end
                    if (m_timer_number !== e.number) begin
                        $error("timer_number: expected %0d got %0d", e.number, m_timer_number);
                        errors++;
                    end
                    if (m_fired_deadline !== e.fired) begin
                        $error("fired_deadline: expected %0h got %0h", e.fired, m_fired_deadline);
                        errors++;
                    end
                    if (m_new_earliest !== e.earliest) begin
                        $error("new_earliest: expected %0b got %0b", e.earliest,
                               m_new_earliest);
                        errors++;
                    end
                    if (m_next_valid !== e.nvalid) begin
                        $error("next_valid: expected %0b got %0b", e.nvalid, m_next_valid);
                        errors++;
                    end
                    if (m_next_deadline !== e.ndeadline) begin
                        $error("next_deadline: expected %0h got %0h", e.ndeadline,
                               m_next_deadline);
                        errors++;
                    end
                    if (m_last !== e.last) begin
                        $error("last: expected %0b got %0b", e.last, m_last); errors++;
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // random deadline: mostly near a moving clock, sometimes extreme
    function automatic logic [TIME_W-1:0] pick_time(input logic [TIME_W-1:0] base);
        case ($urandom_range(9))
            0: return TIME_W'({$urandom(), $urandom()});
            1: return TMAX - TIME_W'($urandom_range(3));
            2: return base;
            default: return base + TIME_W'($urandom_range(60));
        endcase
    endfunction

    function automatic logic [TIME_W-1:0] pick_interval();
        case ($urandom_range(9))
            0, 1, 2, 3: return '0;
            4: return TIME_W'({$urandom(), $urandom()});
            5: return TMAX;
            default: return TIME_W'($urandom_range(1, 40));
        endcase
    endfunction

    command_row_t directed[] = '{
        // after reset: nothing armed
        '{OP_EXPIRE, '0, '0, '0, '0, ST_NONE},
        '{OP_CANCEL, '0, '0, 32'hFFFF_FFFF, '0, ST_NOT_FOUND},
        '{OP_APPEND, TMAX, '0, '0, '0, ST_APPENDED},
        '{OP_APPEND, 48'd0, TMAX, '0, '0, ST_APPENDED},
        '{OP_APPEND, 48'd5, 48'd1, '0, '0, ST_APPENDED},
        '{OP_APPEND, 48'd5, '0, '0, '0, -1},   // tie on deadline, number decides
        '{OP_APPEND, 48'd9, 48'd3, '0, '0, -1},
        '{OP_CANCEL, '0, '0, 32'd4, '0, ST_CANCELLED},
        '{OP_CANCEL, '0, '0, 32'd4, '0, ST_NOT_FOUND},
        '{OP_EXPIRE, '0, '0, '0, 48'd6, -1},   // re-arm overflow saturates
        '{OP_EXPIRE, '0, '0, '0, 48'd3, -1},
        '{OP_EXPIRE, '0, '0, '0, TMAX, -1},    // everything due, periodic ones re-arm
        '{OP_APPEND, 48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA, '0, '0, -1},
        '{OP_APPEND, 48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, '0, '0, -1},
        '{OP_CANCEL, '0, '0, 32'hAAAA_AAAA, '0, ST_NOT_FOUND},
        '{OP_CANCEL, '0, '0, 32'h5555_5555, '0, ST_NOT_FOUND},
        '{OP_EXPIRE, '0, '0, '0, 48'h5555_5555_5555, -1},
        '{OP_EXPIRE, '0, '0, '0, 48'hAAAA_AAAA_AAAA, -1}
    };

    initial begin
        logic [TIME_W-1:0] clock_now;
        int sel;
        for (int i = 0; i < SLOTS; i++) tmr_valid[i] = 1'b0;
        number_next = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[r])
            send_command(directed[r].op, directed[r].deadline, directed[r].interval,
                         directed[r].cancel_id, directed[r].now, directed[r].chk_status);
        // unused operation code: no words expected
        send_command(2'd3, TMAX, TMAX, 32'hFFFF_FFFF, TMAX, -1);
        // fill the table to reach the full status
        for (int i = 0; i < SLOTS + 2; i++)
            send_command(OP_APPEND, TIME_W'($urandom_range(100)), '0, '0, '0, -1);
        send_command(OP_EXPIRE, '0, '0, '0, TMAX, -1);   // burst of sixteen
        send_command(OP_EXPIRE, '0, '0, '0, TMAX, -1);
        wait_drained();   // hold off until every word is back

        // random phases: none, sender idle, receiver stall, both
        clock_now = 48'd1000;
        for (int n = 0; n < N_RANDOM; n++) begin
            case (n / (N_RANDOM / 4))
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
                default: begin send_idle_pct = 11; recv_stall_pct = 11; end
            endcase
            sel = $urandom_range(99);
            if (sel < 50) begin
                send_command(OP_APPEND, pick_time(clock_now), pick_interval(),
                             '0, '0, -1);
            end else if (sel < 68) begin
                send_command(OP_CANCEL, '0, '0,
                             ($urandom_range(3) == 0) ? $urandom()
                                 : number_next - NUM_W'($urandom_range(1, 20)), '0, -1);
            end else if (sel < 97) begin
                clock_now += TIME_W'($urandom_range(40));
                send_command(OP_EXPIRE, '0, '0, '0,
                             ($urandom_range(19) == 0) ? TMAX : clock_now, -1);
            end else begin
                send_command(2'd3, TIME_W'({$urandom(), $urandom()}), '0, $urandom(), '0,
                             -1);
            end
        end

        send_idle_pct = 0;
        recv_stall_pct = 0;
        wait_drained();
        if (errors == 0 && pending_words.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
